// File: rtl/core/lgts_pkg.sv
// shared types, widths and codes of the level gibbs token sampler
// no dependencies; compiled first
package lgts_pkg;

	localparam int LEVELS_DEF     = 3;
	localparam int TOPICS_DEF     = 256;
	localparam int VOCAB_SIZE_DEF = 4096;
	localparam int COUNT_BITS_DEF = 20;

	localparam int CMD_BITS       = 2;
	localparam int LEVEL_BITS     = 2;
	localparam int TOPIC_BITS     = 8;
	localparam int WORD_BITS      = 12;
	localparam int RAND_BITS      = 32;

	localparam int FRAC_BITS      = 16;
	localparam int DOC_BITS       = 16;
	localparam int TOTAL_BITS     = 28;
	localparam int PRIOR_BITS     = 24;
	localparam int VOCAB_REG_BITS = 13;
	localparam int A_BITS         = DOC_BITS + FRAC_BITS + 1;
	localparam int BV_BITS        = PRIOR_BITS + VOCAB_REG_BITS;
	localparam int D_BITS         = TOTAL_BITS + FRAC_BITS + 1;
	localparam int WEIGHT_BITS    = 40;
	localparam int SUM_BITS       = WEIGHT_BITS + 2;
	localparam int PRIOR_REGS     = 3;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA0 = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA2 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BETA0  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BETA2  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_VOCAB  = 3'd6;

	localparam logic [PRIOR_BITS-1:0]     ALPHA_RESET = 24'd65536;
	localparam logic [PRIOR_BITS-1:0]     BETA_RESET  = 24'd6554;
	localparam logic [VOCAB_REG_BITS-1:0] VOCAB_RESET = 13'd4096;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_SET_PATH    = 2'd0,
		CMD_COUNT_LEVEL = 2'd1,
		CMD_ADJUST      = 2'd2,
		CMD_SAMPLE      = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                  command;
		logic [LEVEL_BITS-1:0] level;
		logic [TOPIC_BITS-1:0] topic_id;
		logic [WORD_BITS-1:0]  word_id;
		logic                  increment;
		logic [RAND_BITS-1:0]  random_fraction;
	} req_item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] new_level;
		logic                  sampled;
		logic                  count_error;
	} rsp_item_t;

endpackage

// File: rtl/core/lgts_req_if.sv
// request channel of the token sampler: valid, ready and one request item
// depends on lgts_pkg
interface lgts_req_if;
	import lgts_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/lgts_rsp_if.sv
// result channel of the token sampler: valid, ready and one result item
// depends on lgts_pkg
interface lgts_rsp_if;
	import lgts_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/level_gibbs_token_sampler_top.sv
// top level of the level gibbs token sampler: count memories, sequencer, result register
// depends on lgts_pkg, lgts_req_if, lgts_rsp_if, lgts_weight
//
// Items come in on req and one result item per request leaves on rsp (valid/ready).
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it. After reset the
// block sweeps the word-topic count memory to zero, one entry per cycle (the topic
// totals are cleared in the same sweep); req.ready stays low until the sweep ends.
// One item is worked at a time. A sample first does the read-modify-write of its given
// level's counts, then per level a memory read and a weight unit pass (four partial
// products and 40 divider steps, one quotient bit per cycle; the divider steps are
// skipped when a weight saturates or a divisor is zero), then a threshold multiply, the
// pick and the read-modify-write of the picked level's counts.
// The single-port count memories are read and written back in separate cycles, so
// no access ever overlaps another.
// A new item is taken while a finished result still waits on rsp; a stalled rsp holds
// its item and the next result waits in the sequencer until rsp drains.
module level_gibbs_token_sampler_top #(
	parameter int LEVELS     = lgts_pkg::LEVELS_DEF,
	parameter int TOPICS     = lgts_pkg::TOPICS_DEF,
	parameter int VOCAB_SIZE = lgts_pkg::VOCAB_SIZE_DEF,
	parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lgts_req_if.sink                            req,
	lgts_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [lgts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lgts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import lgts_pkg::*;

	localparam int DEPTH = TOPICS * VOCAB_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = $clog2(TOPICS);
	localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int BW    = COUNT_BITS + FRAC_BITS + 1;
	localparam logic [COUNT_BITS-1:0] WORD_MAX  = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam logic [DOC_BITS-1:0]   DOC_MAX   = '1;

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_RD1   = 13'b0000000000100,
		S_WB1   = 13'b0000000001000,
		S_LRD   = 13'b0000000010000,
		S_LLOAD = 13'b0000000100000,
		S_LCALC = 13'b0000001000000,
		S_THR1  = 13'b0000010000000,
		S_THR2  = 13'b0000100000000,
		S_PICK  = 13'b0001000000000,
		S_RD2   = 13'b0010000000000,
		S_WB2   = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t                  state_q;
	req_item_t               it_q;
	logic                    err_q;
	logic                    sampled_q;
	logic [LIW-1:0]          lvl_i_q;
	logic [LIW-1:0]          picked_q;
	logic [WEIGHT_BITS-1:0]  w_q [LEVELS];
	logic [SUM_BITS-1:0]     sum_q;
	logic [63:0]             plo_s1;
	logic [SUM_BITS-1:0]     thr_q;
	logic [AW-1:0]           clr_q;
	logic [TOPIC_BITS-1:0]   path_q [LEVELS];
	logic [DOC_BITS-1:0]     doc_q [LEVELS];
	logic [PRIOR_BITS-1:0]   alpha_q [PRIOR_REGS];
	logic [PRIOR_BITS-1:0]   beta_q [PRIOR_REGS];
	logic [VOCAB_REG_BITS-1:0] vocab_q;
	rsp_item_t               out_q;
	logic                    out_valid_q;

	logic [COUNT_BITS-1:0]   wt_mem [DEPTH];
	logic [TOTAL_BITS-1:0]   tot_mem [TOPICS];
	logic [COUNT_BITS-1:0]   wt_rd;
	logic [TOTAL_BITS-1:0]   tot_rd;
	logic                    wt_we;
	logic                    tot_we;
	logic [AW-1:0]           wt_addr;
	logic [TW-1:0]           tot_addr;
	logic [COUNT_BITS-1:0]   wt_wd;
	logic [TOTAL_BITS-1:0]   tot_wd;

	logic [TOPIC_BITS-1:0]   topic_sel;
	logic                    up_op;
	logic                    wt_err;
	logic                    tot_err;
	logic [LIW-1:0]          req_lvl;
	logic [LIW-1:0]          it_lvl;
	logic                    w_start;
	logic                    w_done;
	logic [WEIGHT_BITS-1:0]  w_weight;
	logic [A_BITS-1:0]       a_c;
	logic [BW-1:0]           b_c;
	logic [SUM_BITS:0]       thr_c;
	logic [SUM_BITS-1:0]     run_c;
	logic                    found_c;
	logic [LIW-1:0]          pick_c;
	logic                    out_load;

	assign req_lvl = LIW'(req.data.level);
	assign it_lvl  = LIW'(it_q.level);

	// count memories
	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_addr] <= wt_wd;
		end
		wt_rd <= wt_mem[wt_addr];
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_addr] <= tot_wd;
		end
		tot_rd <= tot_mem[tot_addr];
	end

	always_comb begin
		case (state_q)
			S_RD1, S_WB1: begin
				topic_sel = (it_q.command == CMD_ADJUST) ? it_q.topic_id : path_q[it_lvl];
			end
			S_RD2, S_WB2: begin
				topic_sel = path_q[picked_q];
			end
			default: begin
				topic_sel = path_q[lvl_i_q];
			end
		endcase
	end

	always_comb begin
		up_op   = (state_q == S_WB2) || (it_q.command == CMD_ADJUST && it_q.increment);
		wt_err  = up_op ? (wt_rd == WORD_MAX) : (wt_rd == '0);
		tot_err = up_op ? (tot_rd == TOTAL_MAX) : (tot_rd == '0);
		if (state_q == S_CLEAR) begin
			wt_addr  = clr_q;
			tot_addr = TW'(clr_q);
			wt_we    = 1'b1;
			tot_we   = (32'(clr_q) < TOPICS);
			wt_wd    = '0;
			tot_wd   = '0;
		end else begin
			wt_addr  = AW'(topic_sel) * AW'(VOCAB_SIZE) + AW'(it_q.word_id);
			tot_addr = TW'(topic_sel);
			wt_we    = (state_q == S_WB1) || (state_q == S_WB2);
			tot_we   = wt_we;
			if (wt_err) begin
				wt_wd = wt_rd;
			end else begin
				wt_wd = up_op ? wt_rd + 1'b1 : wt_rd - 1'b1;
			end
			if (tot_err) begin
				tot_wd = tot_rd;
			end else begin
				tot_wd = up_op ? tot_rd + 1'b1 : tot_rd - 1'b1;
			end
		end
	end

	// level weight operands
	assign w_start = (state_q == S_LLOAD);
	assign a_c = A_BITS'({doc_q[lvl_i_q], {FRAC_BITS{1'b0}}}) + A_BITS'(alpha_q[lvl_i_q]);
	assign b_c = BW'({wt_rd, {FRAC_BITS{1'b0}}}) + BW'(beta_q[lvl_i_q]);

	lgts_weight #(
		.COUNT_BITS(COUNT_BITS)
	) u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (w_start),
		.a      (a_c),
		.b      (b_c),
		.total  (tot_rd),
		.beta   (beta_q[lvl_i_q]),
		.vocab  (vocab_q),
		.done   (w_done),
		.weight (w_weight)
	);

	assign thr_c = (SUM_BITS+1)'(sum_q[SUM_BITS-1:32]) * (SUM_BITS+1)'(it_q.random_fraction)
		+ (SUM_BITS+1)'(plo_s1[63:32]);

	always_comb begin
		run_c   = '0;
		found_c = 1'b0;
		pick_c  = LIW'(LEVELS - 1);
		for (int i = 0; i < LEVELS; i++) begin
			run_c = run_c + SUM_BITS'(w_q[i]);
			if (!found_c && run_c > thr_q) begin
				pick_c  = LIW'(i);
				found_c = 1'b1;
			end
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			err_q     <= 1'b0;
			sampled_q <= 1'b0;
			lvl_i_q   <= '0;
			picked_q  <= '0;
			sum_q     <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				path_q[i] <= '0;
				doc_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						it_q      <= req.data;
						err_q     <= (req.data.command == CMD_COUNT_LEVEL)
							&& (32'(req.data.level) < LEVELS)
							&& (doc_q[req_lvl] == DOC_MAX);
						sampled_q <= 1'b0;
						lvl_i_q   <= '0;
						sum_q     <= '0;
						case (req.data.command)
							CMD_SET_PATH: begin
								if (32'(req.data.level) < LEVELS
									&& 32'(req.data.topic_id) < TOPICS) begin
									path_q[req_lvl] <= req.data.topic_id;
								end
								state_q <= S_DONE;
							end
							CMD_COUNT_LEVEL: begin
								if (32'(req.data.level) < LEVELS
									&& doc_q[req_lvl] != DOC_MAX) begin
									doc_q[req_lvl] <= doc_q[req_lvl] + 1'b1;
								end
								state_q <= S_DONE;
							end
							CMD_ADJUST: begin
								if (32'(req.data.topic_id) < TOPICS
									&& 32'(req.data.word_id) < VOCAB_SIZE) begin
									state_q <= S_RD1;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_SAMPLE: begin
								if (32'(req.data.level) < LEVELS
									&& 32'(req.data.word_id) < VOCAB_SIZE) begin
									state_q <= S_RD1;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD1: begin
					state_q <= S_WB1;
				end
				S_WB1: begin
					err_q <= wt_err || tot_err
						|| (it_q.command == CMD_SAMPLE && doc_q[it_lvl] == '0);
					if (it_q.command == CMD_SAMPLE) begin
						if (doc_q[it_lvl] != '0) begin
							doc_q[it_lvl] <= doc_q[it_lvl] - 1'b1;
						end
						state_q <= S_LRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LRD: begin
					state_q <= S_LLOAD;
				end
				S_LLOAD: begin
					state_q <= S_LCALC;
				end
				S_LCALC: begin
					if (w_done) begin
						w_q[lvl_i_q] <= w_weight;
						sum_q        <= sum_q + SUM_BITS'(w_weight);
						if (lvl_i_q == LIW'(LEVELS - 1)) begin
							state_q <= S_THR1;
						end else begin
							lvl_i_q <= lvl_i_q + 1'b1;
							state_q <= S_LRD;
						end
					end
				end
				S_THR1: begin
					if (sum_q == '0) begin
						picked_q <= LIW'(LEVELS - 1);
						state_q  <= S_RD2;
					end else begin
						plo_s1  <= 64'(sum_q[31:0]) * 64'(it_q.random_fraction);
						state_q <= S_THR2;
					end
				end
				S_THR2: begin
					thr_q   <= SUM_BITS'(thr_c);
					state_q <= S_PICK;
				end
				S_PICK: begin
					picked_q <= pick_c;
					state_q  <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_WB2;
				end
				S_WB2: begin
					sampled_q <= 1'b1;
					if (wt_err || tot_err || doc_q[picked_q] == DOC_MAX) begin
						err_q <= 1'b1;
					end
					if (doc_q[picked_q] != DOC_MAX) begin
						doc_q[picked_q] <= doc_q[picked_q] + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.new_level   <= sampled_q ? LEVEL_BITS'(picked_q) : '0;
			out_q.sampled     <= sampled_q;
			out_q.count_error <= err_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIOR_REGS; i++) begin
				alpha_q[i] <= ALPHA_RESET;
				beta_q[i]  <= BETA_RESET;
			end
			vocab_q <= VOCAB_RESET;
		end else if (cfg_we) begin
			if (cfg_index inside {[CFG_ALPHA0:CFG_ALPHA2]}) begin
				alpha_q[2'(cfg_index - CFG_ALPHA0)] <= cfg_data;
			end else if (cfg_index inside {[CFG_BETA0:CFG_BETA2]}) begin
				beta_q[2'(cfg_index - CFG_BETA0)] <= cfg_data;
			end else if (cfg_index == CFG_VOCAB) begin
				vocab_q <= VOCAB_REG_BITS'(cfg_data);
			end
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

// File: rtl/core/lgts_weight.sv
// level weight unit: floor(a * b / d) saturated to 40 bits, d = total * 2^16 + beta * vocab
// four partial products, then one quotient bit per cycle; depends on lgts_pkg
module lgts_weight #(
	parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [lgts_pkg::A_BITS-1:0]           a,
	input  logic [COUNT_BITS+lgts_pkg::FRAC_BITS:0] b,
	input  logic [lgts_pkg::TOTAL_BITS-1:0]       total,
	input  logic [lgts_pkg::PRIOR_BITS-1:0]       beta,
	input  logic [lgts_pkg::VOCAB_REG_BITS-1:0]   vocab,
	output logic                                  done,
	output logic [lgts_pkg::WEIGHT_BITS-1:0]      weight
);
	import lgts_pkg::*;

	localparam int BW  = COUNT_BITS + FRAC_BITS + 1;
	localparam int PW  = A_BITS + BW;
	localparam int AL  = (A_BITS + 1) / 2;
	localparam int BL  = (BW + 1) / 2;
	localparam int PPW = AL + BL;
	localparam int DW  = D_BITS;
	localparam int CW  = $clog2(WEIGHT_BITS);

	typedef enum logic [5:0] {
		W_IDLE = 6'b000001,
		W_MUL  = 6'b000010,
		W_PREP = 6'b000100,
		W_CHK  = 6'b001000,
		W_DIV  = 6'b010000,
		W_DONE = 6'b100000
	} wstate_t;

	wstate_t                 state_q;
	logic [A_BITS-1:0]       a_q;
	logic [BW-1:0]           b_q;
	logic [TOTAL_BITS-1:0]   total_q;
	logic [PRIOR_BITS-1:0]   beta_q;
	logic [VOCAB_REG_BITS-1:0] vocab_q;
	logic [1:0]              k_q;
	logic [PW-1:0]           acc_q;
	logic [BV_BITS-1:0]      bv_q;
	logic [DW-1:0]           d_q;
	logic [DW-1:0]           rem_q;
	logic [WEIGHT_BITS-1:0]  low_q;
	logic [WEIGHT_BITS-1:0]  q_q;
	logic [CW-1:0]           cnt_q;

	logic [AL-1:0]  a_part;
	logic [BL-1:0]  b_part;
	logic [PPW-1:0] pp;
	logic [PW-1:0]  pp_sh;
	logic [DW-1:0]  acc_hi;
	logic [DW:0]    rem_sh;
	logic           ge;
	logic [DW:0]    rem_nx;

	always_comb begin
		a_part = k_q[0] ? AL'(a_q[A_BITS-1:AL]) : a_q[AL-1:0];
		b_part = k_q[1] ? BL'(b_q[BW-1:BL]) : b_q[BL-1:0];
		pp     = PPW'(a_part) * PPW'(b_part);
		pp_sh  = (PW'(pp) << (k_q[0] ? AL : 0)) << (k_q[1] ? BL : 0);
		acc_hi = DW'(acc_q[PW-1:WEIGHT_BITS]);
		rem_sh = {rem_q, low_q[WEIGHT_BITS-1]};
		ge     = rem_sh >= (DW+1)'(d_q);
		rem_nx = ge ? rem_sh - (DW+1)'(d_q) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						total_q <= total;
						beta_q  <= beta;
						vocab_q <= vocab;
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= W_MUL;
					end
				end
				W_MUL: begin
					acc_q <= acc_q + pp_sh;
					if (k_q == 2'd0) begin
						bv_q <= BV_BITS'(beta_q) * BV_BITS'(vocab_q);
					end
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= W_PREP;
					end
				end
				W_PREP: begin
					d_q     <= DW'({total_q, {FRAC_BITS{1'b0}}}) + DW'(bv_q);
					state_q <= W_CHK;
				end
				W_CHK: begin
					rem_q <= acc_hi;
					low_q <= acc_q[WEIGHT_BITS-1:0];
					cnt_q <= '0;
					if (d_q == '0) begin
						q_q     <= '0;
						state_q <= W_DONE;
					end else if (acc_hi >= d_q) begin
						q_q     <= '1;
						state_q <= W_DONE;
					end else begin
						q_q     <= '0;
						state_q <= W_DIV;
					end
				end
				W_DIV: begin
					rem_q <= DW'(rem_nx);
					low_q <= {low_q[WEIGHT_BITS-2:0], 1'b0};
					q_q   <= {q_q[WEIGHT_BITS-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(WEIGHT_BITS - 1)) begin
						state_q <= W_DONE;
					end
				end
				W_DONE: begin
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == W_DONE);
	assign weight = q_q;

endmodule

// File: rtl/core/lgts_checker.sv
// port-level checks of the token sampler over time, bound to the top level
// depends on lgts_pkg and level_gibbs_token_sampler_top
module lgts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input lgts_pkg::rsp_item_t rsp_data
);
	import lgts_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result item dropped or changed under stall");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while the previous one is in work");

	a_level_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.sampled |-> rsp_data.new_level == '0)
		else $error("level reported without a sample");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.new_level != 2'd3)
		else $error("sampled level out of range");

endmodule

bind level_gibbs_token_sampler_top lgts_checker u_lgts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
